[hw/rtl/kmst_pkg.sv]
// Shared constants and codes for the minimum spanning tree block.
package kmst_pkg;

    localparam int DEF_MAX_VERTICES = 32;
    localparam int DEF_MAX_EDGES    = 64;
    localparam int DEF_WEIGHT_BITS  = 16;
    localparam int VERTEX_RESET     = 32;

    typedef enum logic [1:0] {
        STATUS_TREE     = 2'd0,
        STATUS_NO_TREE  = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_OVERFLOW = 2'd3
    } status_t;

endpackage

[hw/rtl/kmst_edge_if.sv]
// Edge input channel: one word per undirected weighted edge.
interface kmst_edge_if #(
    parameter int VW = 5,
    parameter int WB = kmst_pkg::DEF_WEIGHT_BITS
);
    logic          valid;
    logic          ready;
    logic [VW-1:0] edge_from;
    logic [VW-1:0] edge_to;
    logic [WB-1:0] edge_weight;
    logic          edge_last;

    modport source (output valid, edge_from, edge_to, edge_weight, edge_last, input ready);
    modport sink   (input valid, edge_from, edge_to, edge_weight, edge_last, output ready);
endinterface

[hw/rtl/kmst_result_if.sv]
// Result output channel: one word per tree edge or status.
interface kmst_result_if #(
    parameter int VW = 5
);
    logic          valid;
    logic          ready;
    logic [VW-1:0] tree_from;
    logic [VW-1:0] tree_to;
    logic [1:0]    status;
    logic          last_result;

    modport source (output valid, tree_from, tree_to, status, last_result, input ready);
    modport sink   (input valid, tree_from, tree_to, status, last_result, output ready);
endinterface

[hw/rtl/kmst_cfg_if.sv]
// Configuration write channel carrying the vertex count.
interface kmst_cfg_if #(
    parameter int CW = 6
);
    logic          valid;
    logic          ready;
    logic [CW-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[hw/rtl/kruskal_min_spanning_tree.sv]
// Load: one edge word per cycle. After the last edge the block is busy and not ready:
// each selection pass reads every stored edge once, then checks the chosen edge, finds
// the set of each endpoint and merges them if they differ; at most one pass per stored edge plus a final pass.
// Results then leave one word at a time, each held until taken; a status result is a single word.
// Next graph is accepted the cycle after the final result word is taken.
// rst_n clears control, edge count and sets; the edge store needs no clearing.
module kruskal_min_spanning_tree #(
    parameter int MAX_VERTICES = kmst_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = kmst_pkg::DEF_MAX_EDGES,
    parameter int WEIGHT_BITS  = kmst_pkg::DEF_WEIGHT_BITS
) (
    input logic          clk,
    input logic          rst_n,
    kmst_cfg_if.sink     cfg,
    kmst_edge_if.sink    edges,
    kmst_result_if.source results
);
    import kmst_pkg::*;

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CW    = VW + 1;
    localparam int EW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int TW    = $clog2(MAX_EDGES + 1);
    localparam int WB    = WEIGHT_BITS;
    localparam int EDW   = WB + 2 * VW;
    localparam int KW    = EDW + EW;
    localparam int VC_RST = (VERTEX_RESET < MAX_VERTICES) ? VERTEX_RESET : MAX_VERTICES;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SCAN   = 8'b0000_0010,
        ST_CHECK  = 8'b0000_0100,
        ST_FIND_U = 8'b0000_1000,
        ST_FIND_V = 8'b0001_0000,
        ST_JOIN   = 8'b0010_0000,
        ST_EMIT   = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    logic [CW-1:0] vc_reg;
    logic [TW-1:0] total_reg;
    logic          ovf_reg;
    logic [VW-1:0] lbl_reg [MAX_VERTICES];
    logic [VW-1:0] taken_reg;
    logic [VW-1:0] emit_k_reg;
    logic [TW-1:0] rd_cnt_reg;
    logic          pipe_vld_reg;
    logic [EW-1:0] pipe_idx_reg;
    logic [KW-1:0] prev_key_reg;
    logic          have_prev_reg;
    logic [KW-1:0] best_key_reg;
    logic          have_best_reg;
    logic [VW-1:0] ru_reg;
    logic [VW-1:0] rv_reg;
    logic          out_vld_reg;
    logic [VW-1:0] out_from_reg;
    logic [VW-1:0] out_to_reg;
    status_t       out_status_reg;
    logic          out_last_reg;

    logic [EDW-1:0] edge_mem [MAX_EDGES];
    logic [EDW-1:0] edge_q_reg;
    logic [2*VW-1:0] res_mem [MAX_VERTICES-1];
    logic [2*VW-1:0] res_q;

    logic [CW-1:0] n_eff;
    logic [CW-1:0] n_m1;
    logic          in_acc;
    logic          in_range;
    logic          full;
    logic          mem_we;
    logic          ovf_next;
    logic [KW-1:0] cand_key;
    logic          cand_ok;
    logic [VW-1:0] best_u;
    logic [VW-1:0] best_v;
    logic [VW-1:0] lbl_addr;
    logic [VW-1:0] lbl_q;
    logic          issue;

    always_comb
    begin
        if (vc_reg == '0)
            n_eff = CW'(1);
        else if (vc_reg > CW'(MAX_VERTICES))
            n_eff = CW'(MAX_VERTICES);
        else
            n_eff = vc_reg;
    end

    assign n_m1     = n_eff - CW'(1);
    assign in_acc   = edges.valid && edges.ready;
    assign in_range = (CW'(edges.edge_from) < n_eff) && (CW'(edges.edge_to) < n_eff);
    assign full     = (total_reg == TW'(MAX_EDGES));
    assign mem_we   = in_acc && in_range && !full;
    assign ovf_next = ovf_reg || (in_acc && in_range && full);
    assign issue    = (state_reg == ST_SCAN) && (rd_cnt_reg < total_reg);

    // The edge index breaks ties so that every stored edge has a distinct key.
    assign cand_key = {edge_q_reg, pipe_idx_reg};
    assign cand_ok  = (!have_prev_reg || cand_key > prev_key_reg)
                   && (!have_best_reg || cand_key < best_key_reg);
    assign best_u   = best_key_reg[EW+2*VW-1:EW+VW];
    assign best_v   = best_key_reg[EW+VW-1:EW];
    assign lbl_addr = (state_reg == ST_FIND_U) ? best_u : best_v;
    assign lbl_q    = lbl_reg[lbl_addr];
    assign res_q    = res_mem[emit_k_reg];

    assign cfg.ready           = 1'b1;
    assign edges.ready         = (state_reg == ST_IDLE);
    assign results.valid       = out_vld_reg;
    assign results.tree_from   = out_from_reg;
    assign results.tree_to     = out_to_reg;
    assign results.status      = out_status_reg;
    assign results.last_result = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            edge_mem[total_reg[EW-1:0]] <= {edges.edge_weight, edges.edge_from, edges.edge_to};
        edge_q_reg <= edge_mem[rd_cnt_reg[EW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_JOIN && ru_reg != rv_reg)
            res_mem[taken_reg] <= {best_u, best_v};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            vc_reg         <= CW'(VC_RST);
            total_reg      <= '0;
            ovf_reg        <= 1'b0;
            taken_reg      <= '0;
            emit_k_reg     <= '0;
            rd_cnt_reg     <= '0;
            pipe_vld_reg   <= 1'b0;
            have_prev_reg  <= 1'b0;
            have_best_reg  <= 1'b0;
            out_vld_reg    <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++)
                lbl_reg[i] <= VW'(i);
        end
        else
        begin
            if (cfg.valid)
                vc_reg <= cfg.data;
            pipe_vld_reg <= issue;
            pipe_idx_reg <= rd_cnt_reg[EW-1:0];
            if (issue)
                rd_cnt_reg <= rd_cnt_reg + TW'(1);
            if (pipe_vld_reg && cand_ok)
            begin
                best_key_reg  <= cand_key;
                have_best_reg <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (mem_we)
                            total_reg <= total_reg + TW'(1);
                        ovf_reg <= ovf_next;
                        if (edges.edge_last)
                        begin
                            out_from_reg <= '0;
                            out_to_reg   <= '0;
                            out_last_reg <= 1'b1;
                            if (ovf_next)
                            begin
                                out_status_reg <= STATUS_OVERFLOW;
                                out_vld_reg    <= 1'b1;
                                state_reg      <= ST_OUT;
                            end
                            else if (n_eff == CW'(1))
                            begin
                                out_status_reg <= STATUS_EMPTY;
                                out_vld_reg    <= 1'b1;
                                state_reg      <= ST_OUT;
                            end
                            else
                            begin
                                for (int i = 0; i < MAX_VERTICES; i++)
                                    lbl_reg[i] <= VW'(i);
                                taken_reg     <= '0;
                                rd_cnt_reg    <= '0;
                                have_prev_reg <= 1'b0;
                                have_best_reg <= 1'b0;
                                state_reg     <= ST_SCAN;
                            end
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (!issue && !pipe_vld_reg)
                        state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (!have_best_reg)
                    begin
                        // Edges exhausted before the tree spans all vertices.
                        out_from_reg   <= '0;
                        out_to_reg     <= '0;
                        out_status_reg <= STATUS_NO_TREE;
                        out_last_reg   <= 1'b1;
                        out_vld_reg    <= 1'b1;
                        state_reg      <= ST_OUT;
                    end
                    else
                    begin
                        prev_key_reg  <= best_key_reg;
                        have_prev_reg <= 1'b1;
                        if (CW'(best_u) >= n_eff || CW'(best_v) >= n_eff)
                        begin
                            rd_cnt_reg    <= '0;
                            have_best_reg <= 1'b0;
                            state_reg     <= ST_SCAN;
                        end
                        else
                            state_reg <= ST_FIND_U;
                    end
                end
                ST_FIND_U:
                begin
                    ru_reg    <= lbl_q;
                    state_reg <= ST_FIND_V;
                end
                ST_FIND_V:
                begin
                    rv_reg    <= lbl_q;
                    state_reg <= ST_JOIN;
                end
                ST_JOIN:
                begin
                    rd_cnt_reg    <= '0;
                    have_best_reg <= 1'b0;
                    state_reg     <= ST_SCAN;
                    if (ru_reg != rv_reg)
                    begin
                        for (int i = 0; i < MAX_VERTICES; i++)
                            if (lbl_reg[i] == rv_reg)
                                lbl_reg[i] <= ru_reg;
                        taken_reg <= taken_reg + VW'(1);
                        if (CW'(taken_reg) + CW'(1) == n_m1)
                        begin
                            emit_k_reg <= '0;
                            state_reg  <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    out_from_reg   <= res_q[2*VW-1:VW];
                    out_to_reg     <= res_q[VW-1:0];
                    out_status_reg <= STATUS_TREE;
                    out_last_reg   <= (emit_k_reg + VW'(1) == taken_reg);
                    out_vld_reg    <= 1'b1;
                    state_reg      <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (results.ready)
                    begin
                        out_vld_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            total_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            emit_k_reg <= emit_k_reg + VW'(1);
                            state_reg  <= ST_EMIT;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> !edges.ready)
        else $error("result word pending while edges are accepted");

    a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && results.last_result) |=> edges.ready)
        else $error("block not idle after final result word");

    a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_JOIN) |-> (CW'(taken_reg) < n_m1))
        else $error("taken edge count passed vertex count minus one");

    a_tree_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.status != STATUS_TREE) |->
        (results.tree_from == '0 && results.tree_to == '0 && results.last_result))
        else $error("status word carries endpoints or is not final");
`endif

endmodule

[tb/tb_kmst_util.sv]
// Testbench helpers: result word type and stored edge type.
package tb_kmst_util;
    import kmst_pkg::*;

    typedef struct packed {
        logic [4:0]  tree_from;
        logic [4:0]  tree_to;
        status_t     status;
        logic        last_result;
    } tree_word_t;

    typedef struct packed {
        logic [4:0]  from_v;
        logic [4:0]  to_v;
        logic [15:0] weight;
    } stored_edge_t;
endpackage

[tb/testbench.sv]
// Self-checking testbench for the minimum spanning tree block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import kmst_pkg::*;
    import tb_kmst_util::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #4 clk = ~clk;

    kmst_cfg_if    cfg_ch ();
    kmst_edge_if   edge_ch ();
    kmst_result_if res_ch ();

    kruskal_min_spanning_tree dut (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_ch.sink), .edges(edge_ch.sink),
        .results(res_ch.source)
    );

    // Predictor state.
    logic [5:0]   vertex_reg;
    stored_edge_t graph_edges[$];
    logic         graph_overflow;
    tree_word_t   tree_expect[$];

    int mismatches = 0;
    int words_seen = 0;
    int graphs_sent = 0;
    int edges_sent = 0;
    bit stall_free = 0;

    function automatic int find_root(ref int parent[32], input int v);
        int r;
        int nxt;
        r = v;
        while (parent[r] != r) r = parent[r];
        while (parent[v] != r) begin
            nxt = parent[v];
            parent[v] = r;
            v = nxt;
        end
        return r;
    endfunction

    function automatic void predict_tree();
        int n;
        int parent[32];
        int rank_v[32];
        int ra;
        int rb;
        int taken;
        stored_edge_t sorted[$];
        stored_edge_t e;
        tree_word_t w;
        tree_word_t tw;
        tree_word_t found[$];
        n = vertex_reg == 0 ? 1 : (vertex_reg > 32 ? 32 : vertex_reg);
        w = '{tree_from: 5'd0, tree_to: 5'd0, status: STATUS_OVERFLOW, last_result: 1'b1};
        if (graph_overflow) begin
            tree_expect = {tree_expect, w};
            return;
        end
        if (n == 1) begin
            w.status = STATUS_EMPTY;
            tree_expect = {tree_expect, w};
            return;
        end
        sorted = graph_edges;
        sorted.sort() with ({item.weight, item.from_v, item.to_v});
        for (int i = 0; i < 32; i++) begin
            parent[i] = i;
            rank_v[i] = 0;
        end
        taken = 0;
        foreach (sorted[i]) begin
            e = sorted[i];
            if (taken >= n - 1) break;
            if (e.from_v >= n || e.to_v >= n) continue;
            ra = find_root(parent, e.from_v);
            rb = find_root(parent, e.to_v);
            if (ra == rb) continue;
            tw.tree_from = e.from_v;
            tw.tree_to = e.to_v;
            tw.status = STATUS_TREE;
            tw.last_result = 1'b0;
            found = {found, tw};
            taken++;
            if (rank_v[ra] < rank_v[rb]) parent[ra] = rb;
            else if (rank_v[ra] > rank_v[rb]) parent[rb] = ra;
            else begin
                parent[rb] = ra;
                if (rank_v[ra] < 7) rank_v[ra]++;
            end
        end
        if (taken < n - 1) begin
            w.status = STATUS_NO_TREE;
            tree_expect = {tree_expect, w};
        end else begin
            found[found.size() - 1].last_result = 1'b1;
            tree_expect = {tree_expect, found};
        end
    endfunction

    // Gap length: mostly zero or short, now and then long.
    function automatic int gap_len();
        if (stall_free) return 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 0;
            5, 6, 7, 8:    return $urandom_range(1, 3);
            default:       return $urandom_range(8, 30);
        endcase
    endfunction

    initial begin
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        edge_ch.valid = 1'b0;
        edge_ch.edge_from = '0;
        edge_ch.edge_to = '0;
        edge_ch.edge_weight = '0;
        edge_ch.edge_last = 1'b0;
        res_ch.ready = 1'b0;
    end

    task automatic send_edge(input int f, input int t, input int wt, input bit last);
        int n;
        stored_edge_t se;
        repeat (gap_len()) @(negedge clk);
        edge_ch.edge_from = f[4:0];
        edge_ch.edge_to = t[4:0];
        edge_ch.edge_weight = wt[15:0];
        edge_ch.edge_last = last;
        edge_ch.valid = 1'b1;
        @(posedge clk);
        while (!edge_ch.ready) @(posedge clk);
        edges_sent++;
        n = vertex_reg == 0 ? 1 : (vertex_reg > 32 ? 32 : vertex_reg);
        if (f < n && t < n) begin
            if (graph_edges.size() < 64) begin
                se = '{from_v: f[4:0], to_v: t[4:0], weight: wt[15:0]};
                graph_edges = {graph_edges, se};
            end
            else graph_overflow = 1'b1;
        end
        if (last) begin
            predict_tree();
            graph_edges.delete();
            graph_overflow = 1'b0;
            graphs_sent++;
        end
        @(negedge clk);
        edge_ch.valid = 1'b0;
    endtask

    // Result side: random back-pressure, compare each word to the oldest prediction.
    initial begin
        tree_word_t got;
        tree_word_t want;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            res_ch.ready = (gap_len() == 0);
            @(posedge clk);
            if (res_ch.valid && res_ch.ready) begin
                got = '{res_ch.tree_from, res_ch.tree_to, status_t'(res_ch.status),
                        res_ch.last_result};
                words_seen++;
                if (tree_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %p", got);
                end else begin
                    want = tree_expect.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end

    task automatic write_vertex_count(input int value);
        while (tree_expect.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        cfg_ch.data = value[5:0];
        cfg_ch.valid = 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        vertex_reg = value[5:0];
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic send_random_graph(input int vmax, input int nedges, input int wmax);
        for (int i = 0; i < nedges; i++)
            send_edge($urandom_range(0, vmax), $urandom_range(0, vmax),
                      $urandom_range(0, wmax), i == nedges - 1);
    endtask

    // A connected tree over the vertices, plus random extra edges, shuffled in.
    task automatic send_connected(input int n, input int extra);
        int f[$];
        int t[$];
        int w[$];
        int j;
        for (int v = 1; v < n; v++) begin
            f.push_front($urandom_range(0, v - 1));
            t.push_front(v);
            w.push_front($urandom);
        end
        for (int k = 0; k < extra; k++) begin
            f.push_front($urandom_range(0, 31));
            t.push_front($urandom_range(0, 31));
            w.push_front($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom);
        end
        for (int k = 0; k < f.size(); k++) begin
            j = $urandom_range(k, f.size() - 1);
            {f[k], f[j]} = {f[j], f[k]};
            {t[k], t[j]} = {t[j], t[k]};
            {w[k], w[j]} = {w[j], w[k]};
        end
        foreach (f[k]) send_edge(f[k], t[k], w[k] & 16'hFFFF, k == f.size() - 1);
    endtask

    task automatic test_directed();
        // Triangle with ties on weight, a self loop and the extreme weights.
        write_vertex_count(3);
        send_edge(0, 0, 0, 1'b0);
        send_edge(2, 1, 65535, 1'b0);
        send_edge(0, 1, 7, 1'b0);
        send_edge(1, 0, 7, 1'b0);
        send_edge(31, 31, 0, 1'b0);
        send_edge(0, 2, 7, 1'b1);
        // Disconnected graph.
        send_edge(0, 1, 1, 1'b1);
        // Single vertex, and a zero count that acts as one.
        write_vertex_count(1);
        send_edge(0, 0, 5, 1'b1);
        write_vertex_count(0);
        send_edge(31, 0, 5, 1'b1);
        // Counts above the maximum saturate.
        write_vertex_count(63);
        send_edge(31, 30, 65535, 1'b1);
    endtask

    task automatic test_overflow();
        write_vertex_count(2);
        for (int i = 0; i < 65; i++) send_edge(i % 2, 1, $urandom_range(0, 65535), i == 64);
        // Exactly full store still computes.
        for (int i = 0; i < 64; i++) send_edge(0, 1, $urandom_range(0, 65535), i == 63);
    endtask

    task automatic test_random();
        int vc;
        for (int g = 0; g < 26; g++) begin
            if (g % 5 == 0) begin
                vc = $urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : $urandom_range(2, 10);
                write_vertex_count(vc);
            end
            stall_free = (g % 7 == 3);
            if ($urandom_range(0, 3) != 0)
                send_connected(vc < 2 ? 2 : (vc > 32 ? 32 : vc), $urandom_range(0, 5));
            else
                send_random_graph(31, $urandom_range(1, 10), 65535);
        end
        stall_free = 0;
        write_vertex_count(32);
        send_connected(32, 8);
    endtask

    initial begin
        vertex_reg = 6'd32;
        graph_overflow = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_overflow();
        test_random();
        while (tree_expect.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        $display("Sent %0d edges in %0d graphs, checked %0d result words.",
                 edges_sent, graphs_sent, words_seen);
        if (mismatches == 0 && tree_expect.size() == 0)
            $display("[kruskal_min_spanning_tree] OK");
        else
            $display("[kruskal_min_spanning_tree] ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout with %0d results outstanding.", tree_expect.size());
        $display("[kruskal_min_spanning_tree] ERROR");
        $finish;
    end
endmodule
